>>> rtl/grwc_pkg.sv
`default_nettype none
package grwc_pkg;

  localparam int MAP_DIM_DEF   = 64;
  localparam int MAX_WIDTH_DEF = 4096;

  localparam int CELL_W     = 6;
  localparam int COL_W      = 12;
  localparam int POS_W      = 22;
  localparam int VEC_W      = 18;
  localparam int SWID_W     = 13;
  localparam int DIST_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFF_FFFF;
  localparam int ONE_Q16 = 65536;

  // Shared divider: numerator and denominator widths.
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 32;

  typedef struct packed {
    logic              operation;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              is_wall;
    logic [COL_W-1:0]  column;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic [CELL_W-1:0] hit_x;
    logic [CELL_W-1:0] hit_y;
    logic              hit_side;
    logic [DIST_W-1:0] wall_distance;
    logic              escaped;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/grid_ray_wall_caster_unit.sv
// Grid ray wall caster.
// Commands arrive on cmd (cmd_valid/cmd_stall); a transfer happens when
// cmd_valid is high and cmd_stall low. A write command stores one map cell
// and gives no result. A cast command gives one result on res
// (res_valid/res_stall), held in an output register until its transfer, so
// the next command can be taken while a result still waits.
// A cast runs four passes of the shared divider (camera position, two
// reciprocal deltas, perpendicular distance; a zero ray component or a
// distance special case skips a pass), the ray multiplies, and for each
// map cell walked a map read, then the wall test.
// Only one command is in work at a time; cmd_stall is low only when idle.
// Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; the port
// is always ready. It must be written only while the block is idle; the
// block itself does not enforce this. After reset the map is cleared one
// cell per cycle, all MAP_DIM*MAP_DIM cells (4096 by default); cmd_stall
// stays high until that pass ends. Registers return to their reset values
// at once. While res_valid and res_stall are both high a finished cast
// waits in its final state until the output register frees.
`default_nettype none
module grid_ray_wall_caster_unit import grwc_pkg::*; #(
  parameter int MAP_DIM   = MAP_DIM_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_DIM);
  localparam int MXW   = ((CW > CELL_W) ? CW : CELL_W) + 2;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CAMW  = 31;
  localparam int PRODW = VEC_W + CAMW;
  localparam int RAYW  = 34;
  localparam int DW    = 33;
  localparam int SW    = 44;
  localparam int NUMW  = MXW + 24;

  typedef enum logic [17:0] {
    S_CLEAR  = 18'd1 << 0,
    S_IDLE   = 18'd1 << 1,
    S_CAM    = 18'd1 << 2,
    S_CAM_W  = 18'd1 << 3,
    S_RAYX   = 18'd1 << 4,
    S_RAYY   = 18'd1 << 5,
    S_RAYY2  = 18'd1 << 6,
    S_DX     = 18'd1 << 7,
    S_DX_W   = 18'd1 << 8,
    S_DY     = 18'd1 << 9,
    S_DY_W   = 18'd1 << 10,
    S_SIDEX  = 18'd1 << 11,
    S_SIDEY  = 18'd1 << 12,
    S_WALK   = 18'd1 << 13,
    S_CHECK  = 18'd1 << 14,
    S_DIST   = 18'd1 << 15,
    S_DIST_W = 18'd1 << 16,
    S_DONE   = 18'd1 << 17
  } state_t;

  state_t state;

  logic [POS_W-1:0]         player_x, player_y;
  logic signed [VEC_W-1:0]  dir_x, dir_y, plane_x, plane_y;
  logic [SWID_W-1:0]        screen_width;
  logic [WW-1:0]            w_eff;

  logic                     mem [DEPTH];
  logic                     mem_we, mem_wdata, mem_re, rd_bit;
  logic [AW-1:0]            mem_waddr, mem_raddr, clr_addr;

  logic [COL_W-1:0]         col_q;
  logic signed [CAMW-1:0]   cam;
  logic signed [PRODW-1:0]  prod;
  logic signed [RAYW-1:0]   rx, ry;
  logic [DW-1:0]            dx, dy;
  logic [SW-1:0]            sx, sy;
  logic signed [MXW-1:0]    mx, my, nmx, nmy;
  logic                     side, esc, step_x, oob;
  logic [DIST_W-1:0]        wall_dist;

  logic [16:0]              frac_sel;
  logic [DW-1:0]            dsel;
  logic [49:0]              side_prod;
  logic signed [NUMW-1:0]   num_s;
  logic signed [RAYW-1:0]   den_s;
  logic [NUMW-1:0]          num_mag;
  logic [RAYW-1:0]          den_mag, rx_mag, ry_mag;
  logic                     cast_go, write_ok;

  div_req_t div_req;
  div_rsp_t div_rsp;

  grwc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x     <= '0;
      player_y     <= '0;
      dir_x        <= 18'sd65536;
      dir_y        <= '0;
      plane_x      <= '0;
      plane_y      <= 18'sd43254;
      screen_width <= 13'd640;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PLAYER_X:     player_x     <= cfg_data[POS_W-1:0];
        REG_PLAYER_Y:     player_y     <= cfg_data[POS_W-1:0];
        REG_DIR_X:        dir_x        <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:        dir_y        <= cfg_data[VEC_W-1:0];
        REG_PLANE_X:      plane_x      <= cfg_data[VEC_W-1:0];
        REG_PLANE_Y:      plane_y      <= cfg_data[VEC_W-1:0];
        REG_SCREEN_WIDTH: screen_width <= cfg_data[SWID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (screen_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(screen_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(screen_width);
    end
  end

  assign rx_mag = rx[RAYW-1] ? RAYW'(-rx) : RAYW'(rx);
  assign ry_mag = ry[RAYW-1] ? RAYW'(-ry) : RAYW'(ry);

  // Walk step: the axis with the smaller side distance advances.
  always_comb begin
    step_x = (sx < sy);
    nmx    = mx;
    nmy    = my;
    if (step_x) begin
      nmx = rx[RAYW-1] ? mx - MXW'(1) : mx + MXW'(1);
    end else begin
      nmy = ry[RAYW-1] ? my - MXW'(1) : my + MXW'(1);
    end
    oob = nmx[MXW-1] || nmy[MXW-1] || ($unsigned(nmx) >= MXW'(MAP_DIM)) ||
          ($unsigned(nmy) >= MXW'(MAP_DIM));
  end

  always_comb begin
    if (state == S_SIDEX) begin
      frac_sel = rx[RAYW-1] ? {1'b0, player_x[15:0]} : 17'h10000 - {1'b0, player_x[15:0]};
      dsel     = dx;
    end else begin
      frac_sel = ry[RAYW-1] ? {1'b0, player_y[15:0]} : 17'h10000 - {1'b0, player_y[15:0]};
      dsel     = dy;
    end
    side_prod = 50'(frac_sel) * 50'(dsel);
  end

  // Signed distance from the player to the crossed boundary.
  always_comb begin
    if (side) begin
      num_s = (NUMW'(my) <<< 16) - NUMW'(player_y) +
              (ry[RAYW-1] ? NUMW'(ONE_Q16) : NUMW'(0));
      den_s = ry;
    end else begin
      num_s = (NUMW'(mx) <<< 16) - NUMW'(player_x) +
              (rx[RAYW-1] ? NUMW'(ONE_Q16) : NUMW'(0));
      den_s = rx;
    end
    num_mag = num_s[NUMW-1] ? NUMW'(-num_s) : NUMW'(num_s);
    den_mag = den_s[RAYW-1] ? RAYW'(-den_s) : RAYW'(den_s);
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state)
      S_CAM: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({col_q, 17'b0});
        div_req.den   = DIV_DW'(w_eff);
      end
      S_DX: begin
        div_req.start = (ry != '0) && (rx != '0);
        div_req.num   = DIV_NW'(64'h1_0000_0000);
        div_req.den   = DIV_DW'(rx_mag);
      end
      S_DY: begin
        div_req.start = (rx != '0) && (ry != '0);
        div_req.num   = DIV_NW'(64'h1_0000_0000);
        div_req.den   = DIV_DW'(ry_mag);
      end
      S_DIST: begin
        div_req.start = (den_s != '0) &&
                        !((num_s != '0) && (num_s[NUMW-1] != den_s[RAYW-1]));
        div_req.num   = DIV_NW'({num_mag, 16'b0});
        div_req.den   = DIV_DW'(den_mag);
      end
      default: ;
    endcase
  end

  assign cast_go  = (state == S_IDLE) && cmd_valid && (cmd.operation == OP_CAST);
  assign write_ok = (state == S_IDLE) && cmd_valid && (cmd.operation == OP_WRITE) &&
                    (32'(cmd.cell_x) < MAP_DIM) && (32'(cmd.cell_y) < MAP_DIM);

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 1'b0;
    end else begin
      mem_we    = write_ok;
      mem_waddr = AW'(cmd.cell_y) * AW'(MAP_DIM) + AW'(cmd.cell_x);
      mem_wdata = cmd.is_wall;
    end
    mem_re    = (state == S_WALK) && !oob;
    mem_raddr = AW'($unsigned(nmy)) * AW'(MAP_DIM) + AW'($unsigned(nmx));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_bit <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cast_go) begin
            col_q <= cmd.column;
            state <= S_CAM;
          end
        end
        S_CAM: begin
          mx    <= MXW'(player_x[POS_W-1:16]);
          my    <= MXW'(player_y[POS_W-1:16]);
          side  <= 1'b0;
          esc   <= 1'b0;
          state <= S_CAM_W;
        end
        S_CAM_W: begin
          if (div_rsp.done) begin
            cam   <= CAMW'({1'b0, div_rsp.quot[29:0]}) - CAMW'(ONE_Q16);
            state <= S_RAYX;
          end
        end
        S_RAYX: begin
          prod  <= PRODW'(plane_x) * PRODW'(cam);
          state <= S_RAYY;
        end
        S_RAYY: begin
          rx    <= RAYW'(dir_x) + RAYW'(prod >>> 16);
          prod  <= PRODW'(plane_y) * PRODW'(cam);
          state <= S_RAYY2;
        end
        S_RAYY2: begin
          ry    <= RAYW'(dir_y) + RAYW'(prod >>> 16);
          state <= S_DX;
        end
        S_DX: begin
          if (ry == '0) begin
            dx    <= '0;
            state <= S_DY;
          end else if (rx == '0) begin
            dx    <= DW'(ONE_Q16);
            state <= S_DY;
          end else begin
            state <= S_DX_W;
          end
        end
        S_DX_W: begin
          if (div_rsp.done) begin
            dx    <= div_rsp.quot[DW-1:0];
            state <= S_DY;
          end
        end
        S_DY: begin
          if (rx == '0) begin
            dy    <= '0;
            state <= S_SIDEX;
          end else if (ry == '0) begin
            dy    <= DW'(ONE_Q16);
            state <= S_SIDEX;
          end else begin
            state <= S_DY_W;
          end
        end
        S_DY_W: begin
          if (div_rsp.done) begin
            dy    <= div_rsp.quot[DW-1:0];
            state <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          sx    <= SW'(side_prod >> 16);
          state <= S_SIDEY;
        end
        S_SIDEY: begin
          sy    <= SW'(side_prod >> 16);
          state <= S_WALK;
        end
        S_WALK: begin
          mx   <= nmx;
          my   <= nmy;
          side <= !step_x;
          if (step_x) begin
            sx <= sx + SW'(dx);
          end else begin
            sy <= sy + SW'(dy);
          end
          if (oob) begin
            esc       <= 1'b1;
            wall_dist <= DIST_MAX;
            state     <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= rd_bit ? S_DIST : S_WALK;
        end
        S_DIST: begin
          if (den_s == '0) begin
            wall_dist <= DIST_MAX;
            state     <= S_DONE;
          end else if ((num_s != '0) && (num_s[NUMW-1] != den_s[RAYW-1])) begin
            wall_dist <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_DIST_W;
          end
        end
        S_DIST_W: begin
          if (div_rsp.done) begin
            wall_dist <= (div_rsp.quot > DIV_NW'(DIST_MAX)) ? DIST_MAX
                                                           : div_rsp.quot[DIST_W-1:0];
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register; a new result loads when the previous one is gone or
  // leaves in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DONE) && (!res_valid || !res_stall)) begin
      res_valid         <= 1'b1;
      res.column_out    <= col_q;
      res.hit_x         <= esc ? '0 : mx[CELL_W-1:0];
      res.hit_y         <= esc ? '0 : my[CELL_W-1:0];
      res.hit_side      <= esc ? 1'b0 : side;
      res.wall_distance <= wall_dist;
      res.escaped       <= esc;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  a_escape_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.escaped |-> (res.wall_distance == DIST_MAX) &&
                                 (res.hit_x == '0) && (res.hit_y == '0) && !res.hit_side)
    else $error("escaped result carries hit data");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_check_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state == S_WALK) && $past(mem_re))
    else $error("wall test without a map read");

  a_no_map_write_in_cast: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR) || (state == S_IDLE))
    else $error("map written during a cast");

endmodule
`default_nettype wire

>>> rtl/grwc_divider.sv
`default_nettype none
module grwc_divider import grwc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;

  // Restoring division, one quotient bit per cycle; the numerator shifts out
  // of quo while the quotient shifts in.
  assign rem_sh = {rem, quo[DIV_NW-1]};
  assign diff   = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (!diff[DIV_DW]) begin
          rem <= diff[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DIV_DW-1:0];
          quo <= {quo[DIV_NW-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule
`default_nettype wire

>>> verif/tb_grid_ray_wall_caster_unit.sv
`default_nettype none
module tb_grid_ray_wall_caster_unit;
  import grwc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 1500;
  localparam int SETTLE_CYCLES  = 16;

  logic                  clk = 1'b1;
  logic                  rst = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PLAYER_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  grid_ray_wall_caster_unit dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the block's registers and wall map.
  logic [POS_W-1:0]  pos_x, pos_y;
  logic [VEC_W-1:0]  dir_x, dir_y, plane_x, plane_y;
  logic [SWID_W-1:0] scr_width;
  bit                wall_cells [MAP_DIM_DEF*MAP_DIM_DEF];

  res_t pending_hits [$];
  int   mismatches = 0;
  int   burst_left = 0;
  int   hold_request = 0;
  int   idle_cycles = 0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint recip_step(longint own, longint other);
    if (other == 0) return 0;
    if (own == 0) return ONE_Q16;
    return 64'h1_0000_0000 / magnitude(own);
  endfunction

  function automatic res_t cast_ray(logic [COL_W-1:0] col);
    longint w, cam, rx, ry, dx, dy, sx, sy, mx, my, stx, sty, px, py, num, den, q;
    bit     side, gone, hit;
    res_t   r;
    w = longint'(scr_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    px = longint'(pos_x);
    py = longint'(pos_y);
    cam = ((longint'(col) * 2) << 16) / w - ONE_Q16;
    rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 16);
    ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 16);
    dx = recip_step(rx, ry);
    dy = recip_step(ry, rx);
    mx = px >> 16;
    my = py >> 16;
    if (rx < 0) begin
      stx = -1;
      sx = ((px & 'hFFFF) * dx) >> 16;
    end else begin
      stx = 1;
      sx = ((ONE_Q16 - (px & 'hFFFF)) * dx) >> 16;
    end
    if (ry < 0) begin
      sty = -1;
      sy = ((py & 'hFFFF) * dy) >> 16;
    end else begin
      sty = 1;
      sy = ((ONE_Q16 - (py & 'hFFFF)) * dy) >> 16;
    end
    side = 1'b0;
    gone = 1'b0;
    hit = 1'b0;
    // The map is tested only after each step, so the start cell never counts.
    while (!gone && !hit) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 1'b0;
      end else begin
        sy += dy;
        my += sty;
        side = 1'b1;
      end
      if (mx < 0 || mx >= MAP_DIM_DEF || my < 0 || my >= MAP_DIM_DEF) gone = 1'b1;
      else if (wall_cells[my*MAP_DIM_DEF + mx]) hit = 1'b1;
    end
    r = '0;
    r.column_out = col;
    r.escaped = gone;
    if (gone) begin
      r.wall_distance = DIST_MAX;
      return r;
    end
    if (!side) begin
      num = mx * ONE_Q16 - px + ((stx < 0) ? ONE_Q16 : 0);
      den = rx;
    end else begin
      num = my * ONE_Q16 - py + ((sty < 0) ? ONE_Q16 : 0);
      den = ry;
    end
    r.hit_x = mx[CELL_W-1:0];
    r.hit_y = my[CELL_W-1:0];
    r.hit_side = side;
    if (den == 0) begin
      r.wall_distance = DIST_MAX;
    end else if (num != 0 && ((num < 0) != (den < 0))) begin
      r.wall_distance = '0;
    end else begin
      q = (magnitude(num) << 16) / magnitude(den);
      r.wall_distance = (q > longint'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
    end
    return r;
  endfunction

  function automatic void apply_cmd(cmd_t c);
    if (c.operation == OP_WRITE) wall_cells[{c.cell_y, c.cell_x}] = c.is_wall;
    else pending_hits.push_back(cast_ray(c.column));
  endfunction

  task automatic send_cmd(cmd_t c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c;
    cmd_valid = 1'b1;
    do @(posedge clk); while (cmd_stall);
    apply_cmd(c);
  endtask

  task automatic write_cell(int x, int y, bit wall);
    cmd_t c;
    c = cmd_t'($bits(cmd_t)'($urandom));
    c.operation = OP_WRITE;
    c.cell_x = x[CELL_W-1:0];
    c.cell_y = y[CELL_W-1:0];
    c.is_wall = wall;
    send_cmd(c);
  endtask

  task automatic cast_column(int col);
    cmd_t c;
    c = cmd_t'($bits(cmd_t)'($urandom));
    c.operation = OP_CAST;
    c.column = col[COL_W-1:0];
    send_cmd(c);
  endtask

  // Waits until every cast has reported and the block has gone quiet.
  task automatic drain;
    @(negedge clk);
    cmd_valid = 1'b0;
    wait (pending_hits.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PLAYER_X:     pos_x = val[POS_W-1:0];
      REG_PLAYER_Y:     pos_y = val[POS_W-1:0];
      REG_DIR_X:        dir_x = val[VEC_W-1:0];
      REG_DIR_Y:        dir_y = val[VEC_W-1:0];
      REG_PLANE_X:      plane_x = val[VEC_W-1:0];
      REG_PLANE_Y:      plane_y = val[VEC_W-1:0];
      REG_SCREEN_WIDTH: scr_width = val[SWID_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_view(int px, int py, int dxv, int dyv, int plx, int ply, int w);
    write_reg(REG_PLAYER_X, px);
    write_reg(REG_PLAYER_Y, py);
    write_reg(REG_DIR_X, dxv);
    write_reg(REG_DIR_Y, dyv);
    write_reg(REG_PLANE_X, plx);
    write_reg(REG_PLANE_Y, ply);
    write_reg(REG_SCREEN_WIDTH, w);
  endtask

  // Reset values, an empty map, and a single wall in the line of sight.
  task automatic test_reset_view;
    cast_column(0);
    cast_column(639);
    cast_column(4095);
    write_cell(3, 0, 1'b1);
    write_cell(0, 1, 1'b1);
    cast_column(320);
    cast_column(0);
    write_cell(63, 63, 1'b1);
    write_cell(3, 0, 1'b0);
    cast_column(320);
    drain();
  endtask

  task automatic test_special_views;
    // Four walls around cell (10,10), one on each axis, four cells away.
    write_cell(14, 10, 1'b1);
    write_cell(10, 14, 1'b1);
    write_cell(6, 10, 1'b1);
    write_cell(10, 6, 1'b1);
    drain();
    // No direction and no plane: the ray walks in +y.
    set_view(10 << 16 | 'h8000, 10 << 16 | 'h4000, 0, 0, 0, 0, 0);
    cast_column(0);
    cast_column(4095);
    drain();
    // Pure y ray: x component zero gives an x-side divisor of zero.
    set_view(10 << 16, 10 << 16, 0, -(1 << 16), 0, 'h3FFFF, 8191);
    cast_column(2048);
    cast_column(0);
    cast_column(4095);
    drain();
    // Extreme vectors, the far map corner, and the widest screen.
    set_view(4194303, 4194303, 'h1FFFF, 'h20000, 'h20000, 'h1FFFF, 4096);
    cast_column(0);
    cast_column(2048);
    cast_column(4095);
    drain();
    set_view(0, 4194303, 'h20000, 'h1FFFF, 'h1FFFF, 'h20000, 1);
    cast_column(0);
    cast_column(1);
    drain();
  endtask

  task automatic random_view(bit extreme);
    int cx, cy;
    if (extreme) begin
      write_reg(REG_PLAYER_X, $urandom_range(0, 4194303));
      write_reg(REG_PLAYER_Y, $urandom_range(0, 4194303));
    end else begin
      cx = $urandom_range(8, 55);
      cy = $urandom_range(8, 55);
      write_reg(REG_PLAYER_X, (cx << 16) | $urandom_range(0, 'hFFFF));
      write_reg(REG_PLAYER_Y, (cy << 16) | $urandom_range(0, 'hFFFF));
    end
    write_reg(REG_DIR_X, $urandom);
    write_reg(REG_DIR_Y, $urandom);
    write_reg(REG_PLANE_X, $urandom);
    write_reg(REG_PLANE_Y, $urandom);
    case ($urandom_range(0, 3))
      0: write_reg(REG_SCREEN_WIDTH, $urandom);
      1: write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 64));
      default: write_reg(REG_SCREEN_WIDTH, $urandom_range(64, 4096));
    endcase
  endtask

  // Walls scattered around the player so that most rays hit something.
  task automatic random_room(int walls, int casts);
    int cx, cy, w;
    cx = int'(pos_x >> 16);
    cy = int'(pos_y >> 16);
    for (int i = 0; i < walls; i++) begin
      if ($urandom_range(0, 4) == 0)
        write_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      else
        write_cell((cx + $urandom_range(0, 14) - 7) & 63, (cy + $urandom_range(0, 14) - 7) & 63,
                   $urandom_range(0, 5) != 0);
    end
    w = (scr_width == 0) ? 1 : int'(scr_width);
    for (int i = 0; i < casts; i++) begin
      if ($urandom_range(0, 7) == 0) cast_column($urandom_range(0, 4095));
      else cast_column($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
    end
    drain();
  endtask

  task automatic test_random_rooms;
    for (int p = 0; p < 6; p++) begin
      random_view(p == 3);
      random_room(12, 30);
    end
  endtask

  // Results are held off while casts keep coming, so the input must stall.
  task automatic test_output_hold;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 8; i++) cast_column($urandom_range(0, 4095));
    drain();
  endtask

  initial begin
    pos_x = '0;
    pos_y = '0;
    dir_x = 18'd65536;
    dir_y = '0;
    plane_x = '0;
    plane_y = 18'd43254;
    scr_width = 13'd640;
    foreach (wall_cells[i]) wall_cells[i] = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The map clear after reset holds the command input off.
    do @(posedge clk); while (cmd_stall);
    test_reset_view();
    test_special_views();
    test_random_rooms();
    test_output_hold();
    test_random_rooms();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver stall pattern: each period picks a stall rate of 0, 25 or 70 percent.
  int stall_pct = 0;
  int stall_age = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (stall_age == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 70;
      endcase
      stall_age = 256;
    end
    stall_age--;
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %p", $time, res);
      end else begin
        want = pending_hits.pop_front();
        check_field("column_out", longint'(want.column_out), longint'(res.column_out));
        check_field("hit_x", longint'(want.hit_x), longint'(res.hit_x));
        check_field("hit_y", longint'(want.hit_y), longint'(res.hit_y));
        check_field("hit_side", longint'(want.hit_side), longint'(res.hit_side));
        check_field("wall_distance", longint'(want.wall_distance),
                    longint'(res.wall_distance));
        check_field("escaped", longint'(want.escaped), longint'(res.escaped));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

>>> files.f
rtl/grwc_pkg.sv
rtl/grwc_divider.sv
rtl/grid_ray_wall_caster_unit.sv
verif/tb_grid_ray_wall_caster_unit.sv
